[design/gsd_pkg.sv]
`timescale 1ns / 1ps

package gsd_pkg;

  localparam int MAX_GROUP_DEF   = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Widths fixed by the register map and the result format.
  localparam int LEN_W  = 9;
  localparam int OUT_W  = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(16);
  localparam logic             MODE_RESET = 1'b0;
  localparam logic [OUT_W-1:0] OUT_MAX    = {OUT_W{1'b1}};

  // Register indexes, taken from paddr[2].
  localparam logic REG_LEN  = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic load;
    logic add;
    logic clr;
  } acc_ctl_t;

  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_sts_t;

endpackage

[design/gsd_alu.sv]
`timescale 1ns / 1ps

module gsd_alu #(
  parameter int W = 48
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         ge
);

  logic [W:0] sum_ext;

  assign sum_ext = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
  assign res     = sum_ext[W-1:0];
  // With subtraction, no borrow out means a >= b.
  assign ge      = ~sum_ext[W];

endmodule

[design/gsd_accum.sv]
`timescale 1ns / 1ps

module gsd_accum #(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 9,
  parameter int SUM_W       = 25,
  parameter int SQ_W        = 39
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gsd_pkg::acc_ctl_t             ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SUM_W-1:0]       sum,
  output logic        [SQ_W-1:0]        sumsq,
  output logic        [CNT_W-1:0]       count
);
  import gsd_pkg::*;

  logic signed [SAMPLE_BITS-1:0]   sample_r;
  logic signed [SUM_W-1:0]         sum_r, sum_nxt;
  logic        [SQ_W-1:0]          sumsq_r, sumsq_nxt;
  logic        [CNT_W-1:0]         count_r, count_nxt;
  logic        [SAMPLE_BITS-1:0]   mag;
  logic        [2*SAMPLE_BITS-1:0] sq;

  // The most negative sample has a magnitude that still fits unsigned.
  assign mag = sample_r[SAMPLE_BITS-1] ? $unsigned(-sample_r) : $unsigned(sample_r);
  assign sq  = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    count_nxt = count_r;
    if (ctl.clr) begin
      sum_nxt   = '0;
      sumsq_nxt = '0;
      count_nxt = '0;
    end else if (ctl.add) begin
      sum_nxt   = sum_r + SUM_W'(sample_r);
      sumsq_nxt = sumsq_r + SQ_W'(sq);
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_r <= sample_in;
    end
  end

  assign sum   = sum_r;
  assign sumsq = sumsq_r;
  assign count = count_r;

endmodule

[design/gsd_seq.sv]
`timescale 1ns / 1ps

module gsd_seq #(
  parameter int CNT_W = 9,
  parameter int SUM_W = 25,
  parameter int SQ_W  = 39
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gsd_pkg::seq_ctl_t          ctl,
  output gsd_pkg::seq_sts_t          sts,
  input  logic        [CNT_W-1:0]    count,
  input  logic signed [SUM_W-1:0]    sum,
  input  logic        [SQ_W-1:0]     sumsq,
  input  logic                       unbiased,
  output logic [gsd_pkg::OUT_W-1:0]  dev
);
  import gsd_pkg::*;

  localparam int NUM_W  = CNT_W + SQ_W;
  localparam int ACC_W  = NUM_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int RT_W   = (NUM_W + 1) / 2;
  localparam int RAD_W  = 2 * RT_W;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int SAT_W  = (RT_W > OUT_W) ? RT_W : OUT_W;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DEN   = 3'd1;
  localparam logic [2:0] PH_NUM_P = 3'd2;
  localparam logic [2:0] PH_NUM_S = 3'd3;
  localparam logic [2:0] PH_DIV   = 3'd4;
  localparam logic [2:0] PH_SQRT  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt, step_lim;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [SUM_W-1:0]  mplier_r, mplier_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [RT_W-1:0]   root_r, root_nxt;
  logic [OUT_W-1:0]  dev_r, dev_nxt;

  logic [ACC_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_ge;
  logic [ACC_W-1:0]  mul_acc, div_sh, sqrt_sh, trial;
  logic [CNT_W-1:0]  divisor;
  logic [SUM_W-1:0]  abs_sum;
  logic [RT_W-1:0]   root_fin;
  logic [SAT_W-1:0]  root_ext;
  logic              last_step;

  gsd_alu #(.W(ACC_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .ge  (alu_ge)
  );

  assign divisor  = (unbiased && (count > CNT_W'(1))) ? (count - CNT_W'(1)) : count;
  assign abs_sum  = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
  assign mul_acc  = mplier_r[0] ? alu_res : acc_r;
  assign div_sh   = {acc_r[ACC_W-2:0], mcand_r[ACC_W-1]};
  assign sqrt_sh  = {acc_r[ACC_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = ACC_W'({root_r, 2'b01});
  assign root_fin = {root_r[RT_W-2:0], alu_ge};
  assign root_ext = SAT_W'(root_fin);

  always_comb begin
    alu_a   = acc_r;
    alu_b   = mcand_r;
    alu_sub = 1'b0;
    case (phase_r)
      PH_NUM_S: alu_sub = 1'b1;
      PH_DIV: begin
        alu_a   = div_sh;
        alu_b   = ACC_W'(den_r);
        alu_sub = 1'b1;
      end
      PH_SQRT: begin
        alu_a   = sqrt_sh;
        alu_b   = trial;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_NUM_S: step_lim = STEP_W'(SUM_W - 1);
      PH_DIV:   step_lim = STEP_W'(NUM_W - 1);
      PH_SQRT:  step_lim = STEP_W'(RT_W - 1);
      default:  step_lim = STEP_W'(CNT_W - 1);
    endcase
  end

  assign last_step = (step_r == step_lim);

  always_comb begin
    phase_nxt  = phase_r;
    step_nxt   = step_r + STEP_W'(1);
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    den_nxt    = den_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    dev_nxt    = dev_r;
    unique case (phase_r)
      PH_IDLE: begin
        step_nxt = '0;
        if (ctl.start) begin
          acc_nxt    = '0;
          mcand_nxt  = ACC_W'(divisor);
          mplier_nxt = SUM_W'(count);
          phase_nxt  = PH_DEN;
        end
      end
      PH_DEN: begin
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        if (last_step) begin
          den_nxt    = mul_acc[DEN_W-1:0];
          acc_nxt    = '0;
          mcand_nxt  = ACC_W'(sumsq);
          mplier_nxt = SUM_W'(count);
          step_nxt   = '0;
          phase_nxt  = PH_NUM_P;
        end
      end
      PH_NUM_P: begin
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        if (last_step) begin
          mcand_nxt  = ACC_W'(abs_sum);
          mplier_nxt = abs_sum;
          step_nxt   = '0;
          phase_nxt  = PH_NUM_S;
        end
      end
      PH_NUM_S: begin
        // Subtract the square of the sum, one partial product per cycle.
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        if (last_step) begin
          mcand_nxt = mul_acc;
          acc_nxt   = '0;
          step_nxt  = '0;
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        // Restoring division: the dividend shifts out of mcand while the
        // quotient bits shift in behind it.
        acc_nxt   = alu_ge ? alu_res : div_sh;
        mcand_nxt = {mcand_r[ACC_W-2:0], alu_ge};
        if (last_step) begin
          rad_nxt   = RAD_W'({mcand_r[ACC_W-2:0], alu_ge});
          acc_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          phase_nxt = PH_SQRT;
        end
      end
      PH_SQRT: begin
        acc_nxt  = alu_ge ? alu_res : sqrt_sh;
        root_nxt = root_fin;
        rad_nxt  = rad_r << 2;
        if (last_step) begin
          dev_nxt   = (root_ext > SAT_W'(OUT_MAX)) ? OUT_MAX : root_ext[OUT_W-1:0];
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        step_nxt = '0;
        if (ctl.ack) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        step_nxt  = '0;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      step_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    den_r    <= den_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    dev_r    <= dev_nxt;
  end

  assign sts.busy = (phase_r != PH_IDLE);
  assign sts.done = (phase_r == PH_DONE);
  assign dev      = dev_r;

endmodule

[design/group_standard_deviation_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Ports
// in        sink       in_valid, in_stall, in_sample_value
// out       source     out_valid, out_stall, out_deviation_value
// cfg       APB slave  cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata,
//                      cfg_prdata, cfg_pready
//
// Every sample is first registered, and then the sum, sum of squares
// and count are updated with it.
// A closing sample then goes to the sequencer, whose shared add/subtract unit
// does two shift-add products, one shift-subtract square, a restoring
// division and a digit-by-digit square root, one step per cycle.
// Reset is synchronous and active low; the group length returns to 16 and the
// mode to biased. The finished result sits in an output register, so the next
// sample is taken while out_stall holds the previous result.

module group_standard_deviation_top #(
  parameter int MAX_GROUP   = gsd_pkg::MAX_GROUP_DEF,
  parameter int SAMPLE_BITS = gsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [gsd_pkg::OUT_W-1:0]   out_deviation_value,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic        [gsd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic        [gsd_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic        [gsd_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import gsd_pkg::*;

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_GROUP) + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_GROUP);
  localparam int EL_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACC   = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_CALC  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] group_length_r;
  logic             unbiased_r;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;

  acc_ctl_t                acc_ctl;
  seq_ctl_t                seq_ctl;
  seq_sts_t                seq_sts;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]         acc_sumsq;
  logic [CNT_W-1:0]        acc_count, count_inc;
  logic [EL_W-1:0]         len_ext, eff_len;
  logic [OUT_W-1:0]        seq_dev;
  logic                    cfg_wr, closing, result_load;

  gsd_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .sample_in (in_sample_value),
    .sum       (acc_sum),
    .sumsq     (acc_sumsq),
    .count     (acc_count)
  );

  gsd_seq #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .SQ_W  (SQ_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (seq_ctl),
    .sts      (seq_sts),
    .count    (acc_count),
    .sum      (acc_sum),
    .sumsq    (acc_sumsq),
    .unbiased (unbiased_r),
    .dev      (seq_dev)
  );

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_length_r <= LEN_RESET;
      unbiased_r     <= MODE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_LEN:  group_length_r <= cfg_pwdata[LEN_W-1:0];
        REG_MODE: unbiased_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_LEN:  cfg_prdata = DATA_W'(group_length_r);
      REG_MODE: cfg_prdata = DATA_W'(unbiased_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // A zero length counts as one; lengths above the maximum saturate.
  assign len_ext   = EL_W'(group_length_r);
  assign eff_len   = (len_ext == '0) ? EL_W'(1) :
                     (len_ext > EL_W'(MAX_GROUP)) ? EL_W'(MAX_GROUP) : len_ext;
  assign count_inc = acc_count + CNT_W'(1);
  assign closing   = (EL_W'(count_inc) >= eff_len);

  assign result_load = (state_r == ST_CALC) && seq_sts.done && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    acc_ctl.load  = 1'b0;
    acc_ctl.add   = 1'b0;
    acc_ctl.clr   = 1'b0;
    seq_ctl.start = 1'b0;
    seq_ctl.ack   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acc_ctl.load = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_ctl.add = 1'b1;
        state_nxt   = closing ? ST_START : ST_IDLE;
      end
      ST_START: begin
        seq_ctl.start = 1'b1;
        state_nxt     = ST_CALC;
      end
      ST_CALC: begin
        if (result_load) begin
          seq_ctl.ack = 1'b1;
          acc_ctl.clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (result_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_data_r <= seq_dev;
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_deviation_value = out_data_r;

`ifndef SYNTHESIS
  a_result_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_CALC)
    else $error("result beat raised outside the calculation state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_count <= CNT_W'(MAX_GROUP))
    else $error("sample count beyond the largest group");

  a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !seq_sts.busy)
    else $error("sequencer busy while samples are taken");

  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && seq_sts.done && !out_stall) |=> out_valid_r)
    else $error("finished deviation not moved to the output register");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import gsd_pkg::*;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int SETTLE      = 160;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL   = 900;

  // Mirrors the group statistics and predicts the deviation of each closed group.
  class deviation_scoreboard;
    logic [LEN_W-1:0]  length_reg;
    logic              unbiased_reg;
    longint            group_sum;
    longint unsigned   group_square_sum;
    longint unsigned   group_count;
    logic [OUT_W-1:0]  deviation_q[$];
    int                errors;

    function new();
      length_reg       = LEN_RESET;
      unbiased_reg     = MODE_RESET;
      group_sum        = 0;
      group_square_sum = 0;
      group_count      = 0;
      errors           = 0;
    endfunction

    function void write_reg(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_LEN) begin
        length_reg = value[LEN_W-1:0];
      end else begin
        unbiased_reg = value[0];
      end
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) begin
          root = trial;
        end
      end
      return root;
    endfunction

    function void note_sample(logic signed [SW-1:0] beat);
      longint          v;
      longint unsigned eff;
      longint unsigned n;
      longint unsigned divisor;
      longint unsigned mag_sum;
      longint unsigned spread;
      longint unsigned root;
      v = longint'(beat);
      group_sum        += v;
      group_square_sum += longint'(v * v);
      group_count      += 1;
      eff = (length_reg == 0) ? 1 : length_reg;
      if (eff > MAX_GROUP_DEF) begin
        eff = MAX_GROUP_DEF;
      end
      if (group_count < eff) begin
        return;
      end
      n       = group_count;
      divisor = (unbiased_reg && n > 1) ? n - 1 : n;
      mag_sum = (group_sum < 0) ? -group_sum : group_sum;
      spread  = (n * group_square_sum - mag_sum * mag_sum) / (n * divisor);
      root    = floor_root(spread);
      if (root > OUT_MAX) begin
        root = OUT_MAX;
      end
      deviation_q.push_back(root[OUT_W-1:0]);
      group_sum        = 0;
      group_square_sum = 0;
      group_count      = 0;
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (deviation_q.size() == 0) begin
        $error("deviation_value: no result expected, got %0d", got);
        errors++;
        return;
      end
      want = deviation_q.pop_front();
      if (got !== want) begin
        $error("deviation_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return deviation_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SW-1:0]     in_sample_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [OUT_W-1:0]         out_deviation_value;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]        cfg_paddr = '0;
  logic [DATA_W-1:0]        cfg_pwdata = '0;
  logic [DATA_W-1:0]        cfg_prdata;
  logic                     cfg_pready;

  deviation_scoreboard sb = new();
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  cycle_count = 0;
  int  items_sent = 0;

  group_standard_deviation_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_deviation_value (out_deviation_value),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both channels are observed with the values they held just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_sample_value);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_deviation_value);
      end
    end
  end

  // After each result the receiver picks a stall length; the stall then stays
  // up through the idle time and holds the next result until stall_left runs out.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        stall_left = calm ? 0 : $urandom_range(0, 6);
        out_stall <= (stall_left != 0);
      end else if (out_valid && out_stall) begin
        stall_left = stall_left - 1;
        if (stall_left <= 0) begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_sample(input logic [SW-1:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Lets the block drain: all expected results back, then a settling wait
  // with in_valid low.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    want = (idx == REG_LEN) ? (value & DATA_W'(9'h1FF)) : (value & DATA_W'(1));
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("prdata: expected %0h, actual %0h", want, cfg_prdata);
      sb.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [SW-1:0] draw_sample(int style, logic [SW-1:0] base);
    logic [SW-1:0] v;
    case (style)
      0: v = SW'($urandom());
      1: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      2: v = base + SW'($urandom_range(0, 15)) - SW'(8);
      default: v = base;
    endcase
    return v;
  endfunction

  initial begin
    int                pick;
    int                eff;
    int                total;
    int                style;
    logic [LEN_W-1:0]  len;
    logic [SW-1:0]     base;
    logic [SW-1:0]     reset_group[16];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a group of 16 with both extremes and sign boundaries.
    reset_group = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001,
                    16'h7FFE, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00, 16'h8000,
                    16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000};
    foreach (reset_group[i]) send_sample(reset_group[i]);
    drain();

    // Groups of one always give zero; a length of zero behaves the same.
    write_reg(REG_LEN, 1);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    drain();
    write_reg(REG_LEN, 0);
    send_sample(16'h0001);
    drain();

    // Largest spread: a pair at opposite extremes, unbiased and then biased.
    write_reg(REG_LEN, 2);
    write_reg(REG_MODE, 1);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    drain();
    write_reg(REG_MODE, 0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    drain();

    // Length lowered below the count already gathered: the next sample closes.
    write_reg(REG_LEN, 4);
    send_sample(16'h1234);
    send_sample(16'hF00D);
    send_sample(16'h0042);
    drain();
    write_reg(REG_LEN, 2);
    send_sample(16'h7000);
    drain();

    // Mode switched with a group part full; the closing sample sees the new mode.
    write_reg(REG_LEN, 3);
    send_sample(16'h0300);
    send_sample(16'hFD00);
    drain();
    write_reg(REG_MODE, 1);
    send_sample(16'h0000);
    drain();

    // Unbiased with a single sample divides by one.
    write_reg(REG_LEN, 1);
    send_sample(16'h4000);
    drain();

    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        len = '0;
      end else if (pick < 9) begin
        len = LEN_W'($urandom_range(257, 511));
      end else if (pick < 12) begin
        len = LEN_W'($urandom_range(255, 256));
      end else if (pick < 60) begin
        len = LEN_W'($urandom_range(1, 8));
      end else begin
        len = LEN_W'($urandom_range(9, 40));
      end
      eff = (len == 0) ? 1 : ((len > MAX_GROUP_DEF) ? MAX_GROUP_DEF : len);
      calm = 1'b0;
      write_reg(REG_LEN, DATA_W'(len));
      write_reg(REG_MODE, $urandom_range(0, 1));
      calm  = ($urandom_range(0, 4) == 0);
      total = (eff >= 128) ? eff : eff * $urandom_range(1, 4);
      // Some phases add extra samples, often stopping part way into a group so
      // that the next setting lands on a partly filled accumulator.
      if ($urandom_range(0, 5) == 0) begin
        total += $urandom_range(1, eff);
      end
      style = $urandom_range(0, 3);
      base  = SW'($urandom());
      repeat (total) send_sample(draw_sample(style, base));
      drain();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
